### rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared types for the sorted priority queue
// Action and status codes, and the per-cell control bundle.
// ----------------------------------------------------------------------------
package spq_pkg;

    typedef enum logic {
        ACT_ENQ = 1'b0,
        ACT_DEQ = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Control seen by one cell of the row
    typedef struct packed {
        logic enq;   // insert the new value this cycle
        logic deq;   // pop the head this cycle
        logic live;  // cell holds a live entry
        logic tail;  // cell is the first free slot
    } t_cell_ctrl;

endpackage

### rtl/spq_if.sv
// ----------------------------------------------------------------------------
// spq_req_if / spq_rsp_if: request and response channels
// Valid/ready channels; a transfer happens when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface spq_req_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic signed [31:0] value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

interface spq_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] removed_value;
    logic [3:0]         occupancy;

    modport source (output valid, output status, output removed_value, output occupancy,
                    input ready);
    modport sink   (input valid, input status, input removed_value, input occupancy,
                    output ready);
endinterface

### rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted row
// Compares the incoming value with its entry and shifts right on insert,
// left on pop.
// ----------------------------------------------------------------------------
module spq_cell
    import spq_pkg::*;
#(
    parameter int VW = 32
) (
    input  logic                 i_clk,
    input  t_cell_ctrl           i_ctrl,
    input  logic signed [VW-1:0] i_value,       // value being inserted
    input  logic signed [VW-1:0] i_left_value,
    input  logic                 i_left_shift,
    input  logic signed [VW-1:0] i_right_value,
    output logic signed [VW-1:0] o_value,
    output logic                 o_shift        // this cell is at or past the slot
);

    logic signed [VW-1:0] r_entry;
    logic signed [VW-1:0] n_entry;
    logic                 w_ge;

    assign w_ge    = i_ctrl.live && (i_value <= r_entry);
    assign o_shift = w_ge || i_ctrl.tail;
    assign o_value = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.enq) begin
            if (i_left_shift) begin
                n_entry = i_left_value;
            end else if (o_shift) begin
                n_entry = i_value;
            end
        end else if (i_ctrl.deq) begin
            n_entry = i_right_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

### rtl/sorted_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit: min-priority queue as a sorted row of cells
// Latency: the result of an item is valid on the cycle after its transfer.
// Throughput: one item per cycle unless the sink stalls; every cell compares
// and shifts in parallel in the same edge, and the response register is
// refilled while it drains. Reset (synchronous, active low) empties the
// queue and drops any pending response; the stored values are not cleared.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit
    import spq_pkg::*;
#(
    parameter int CAPACITY    = 8,
    parameter int VALUE_WIDTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    spq_req_if.sink       i_req,
    spq_rsp_if.source     o_rsp
);

    localparam int CW = $clog2(CAPACITY + 1);

    // Fill count: entries 0 .. r_count-1 are live, ascending
    logic [CW-1:0]            r_count;
    logic [CW-1:0]            n_count;

    // Response register
    logic                     r_out_valid;
    t_status                  r_status;
    t_status                  n_status;
    logic signed [31:0]       r_removed;
    logic signed [31:0]       n_removed;
    logic [3:0]               r_occ;

    logic                     w_xfer;
    logic                     w_full;
    logic                     w_empty;
    logic                     w_do_enq;
    logic                     w_do_deq;
    logic [63:0]              w_in64;
    logic signed [VALUE_WIDTH-1:0] w_v;
    logic signed [63:0]       w_head64;

    logic signed [VALUE_WIDTH-1:0] w_val   [CAPACITY];
    logic                          w_shift [CAPACITY];

    // Space for a new item whenever the response register is empty or draining
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_xfer      = i_req.valid && i_req.ready;

    assign w_full   = (r_count == CW'(CAPACITY));
    assign w_empty  = (r_count == '0);
    assign w_do_enq = w_xfer && (i_req.action == ACT_ENQ) && !w_full;
    assign w_do_deq = w_xfer && (i_req.action == ACT_DEQ) && !w_empty;

    // Input value zero-padded, then cut to the stored width and read as signed
    assign w_in64 = {32'b0, i_req.value};
    assign w_v    = w_in64[VALUE_WIDTH-1:0];

    // Head of the row, sign-extended before cutting to the port width
    assign w_head64 = 64'(w_val[0]);

    // Row of cells: cell k hands its value and shift flag to cell k+1 and
    // takes its right neighbor's value on a pop; the last cell keeps its own.
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        t_cell_ctrl                    ctrl;
        logic signed [VALUE_WIDTH-1:0] left_value;
        logic                          left_shift;
        logic signed [VALUE_WIDTH-1:0] right_value;

        assign ctrl.enq  = w_do_enq;
        assign ctrl.deq  = w_do_deq;
        assign ctrl.live = (CW'(k) < r_count);
        assign ctrl.tail = (CW'(k) == r_count);

        if (k == 0) begin : g_first
            assign left_value = '0;
            assign left_shift = 1'b0;
        end else begin : g_inner
            assign left_value = w_val[k-1];
            assign left_shift = w_shift[k-1];
        end

        if (k == CAPACITY - 1) begin : g_last
            assign right_value = w_val[k];
        end else begin : g_body
            assign right_value = w_val[k+1];
        end

        spq_cell #(
            .VW (VALUE_WIDTH)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (ctrl),
            .i_value       (w_v),
            .i_left_value  (left_value),
            .i_left_shift  (left_shift),
            .i_right_value (right_value),
            .o_value       (w_val[k]),
            .o_shift       (w_shift[k])
        );
    end

    // Next count and response fields
    always_comb begin
        n_count   = r_count;
        n_status  = ST_OK;
        n_removed = '0;
        if (i_req.action == ACT_ENQ) begin
            if (w_full) begin
                n_status = ST_FULL;
            end else begin
                n_count = r_count + 1'b1;
            end
        end else begin
            if (w_empty) begin
                n_status = ST_EMPTY;
            end else begin
                n_count   = r_count - 1'b1;
                n_removed = w_head64[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_xfer) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload of the response; held while the sink stalls
    always_ff @(posedge i_clk) begin
        if (w_xfer) begin
            r_status  <= n_status;
            r_removed <= n_removed;
            r_occ     <= 4'(n_count);
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_status;
    assign o_rsp.removed_value = r_removed;
    assign o_rsp.occupancy     = r_occ;

endmodule

### rtl/spq_checker.sv
// ----------------------------------------------------------------------------
// spq_checker: port-level checks for the sorted priority queue
// Watches the response channel and ties status codes to occupancy.
// ----------------------------------------------------------------------------
module spq_checker
    import spq_pkg::*;
#(
    parameter int CAPACITY = 8
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [1:0]  i_rsp_status,
    input logic [31:0] i_rsp_removed,
    input logic [3:0]  i_rsp_occupancy
);

    // A stalled response keeps its payload
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_status)
            && $stable(i_rsp_removed) && $stable(i_rsp_occupancy))
        else $error("response changed while stalled");

    // An empty pop reports an empty queue and no value
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status == ST_EMPTY |-> i_rsp_occupancy == 4'd0
            && i_rsp_removed == 32'd0)
        else $error("empty status with nonzero occupancy or value");

    // A refused insert only happens at capacity
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status == ST_FULL |-> i_rsp_occupancy == 4'(CAPACITY))
        else $error("full status below capacity");

    // Status codes stay within the defined set
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> i_rsp_status == ST_OK || i_rsp_status == ST_FULL
            || i_rsp_status == ST_EMPTY)
        else $error("undefined status code");

endmodule

bind sorted_priority_queue_unit spq_checker #(
    .CAPACITY (CAPACITY)
) u_spq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_rsp_valid     (o_rsp.valid),
    .i_rsp_ready     (o_rsp.ready),
    .i_rsp_status    (o_rsp.status),
    .i_rsp_removed   (o_rsp.removed_value),
    .i_rsp_occupancy (o_rsp.occupancy)
);
